### rtl/cfa_pkg.sv
`default_nettype none

package cfa_pkg;

    localparam int NUM_CELLS_DEFAULT = 64;

    localparam logic [7:0] FREE_MARK = 8'd46;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_COMPACT = 2'd2;
    localparam logic [1:0] MODE_READ    = 2'd3;

    localparam logic [1:0] FIT_FIRST   = 2'd0;
    localparam logic [1:0] FIT_BEST    = 2'd1;
    localparam logic [1:0] FIT_WORST   = 2'd2;
    localparam logic [1:0] FIT_ILLEGAL = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd2;

    localparam logic [6:0] FREED_MAX = 7'd127;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] fit_policy;
        logic [7:0] owner_tag;
        logic [6:0] block_size;
        logic [5:0] cell_index;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] start_address;
        logic [6:0] cells_freed;
        logic [7:0] cell_tag;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic is_free;
    } run_ctl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FILL,
        ST_FREE,
        ST_COMPACT,
        ST_PAD,
        ST_READ,
        ST_READ_WAIT,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

### rtl/contiguous_fit_allocator.sv
`default_nettype none

// Allocator over a row of NUM_CELLS owner-tag cells held in a single-port-write,
// single-port-read memory that handles one cell per cycle, so every request is
// processed serially and req_ready is low until its result is queued. After
// reset the block first runs a clearing pass over all NUM_CELLS cells before it
// takes its first request. An illegal request skips the memory and goes straight
// to its result; an allocate request scans every cell and then, when a hole fits,
// writes its owner tag into each granted cell; a free request frees each cell of
// its owner tag; a compact request packs the used cells to the front and marks
// the rest free; and a read request reads its one cell. The response register
// lets a new request be taken while a result still waits.
module contiguous_fit_allocator #(
    parameter int NUM_CELLS = cfa_pkg::NUM_CELLS_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire cfa_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output cfa_pkg::rsp_t      rsp_data
);

    localparam int ADDR_W = $clog2(NUM_CELLS);
    localparam int CNT_W  = $clog2(NUM_CELLS + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(NUM_CELLS);
    localparam logic [CNT_W-1:0] N_LAST = CNT_W'(NUM_CELLS - 1);

    cfa_pkg::state_t   state_reg, state_next;
    cfa_pkg::req_t     req_reg, req_next;
    cfa_pkg::rsp_t     res_reg, res_next;
    cfa_pkg::rsp_t     rsp_data_reg, rsp_data_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  wptr_reg, wptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0] rd_addr_d_reg, rd_addr_d_next;

    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;

    cfa_pkg::run_ctl_t run_ctl;
    logic              run_found;
    logic [ADDR_W-1:0] run_best_start;

    logic              accept;
    logic              alloc_bad;
    logic              free_bad;
    logic              read_bad;
    logic              stream_done;
    logic              fill_done;
    logic              rsp_load;
    logic [6:0]        freed_sat;

    cfa_store #(
        .NUM_CELLS (NUM_CELLS),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    cfa_run_unit #(
        .NUM_CELLS (NUM_CELLS),
        .ADDR_W    (ADDR_W),
        .CNT_W     (CNT_W)
    ) u_run_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (run_ctl),
        .index      (rd_addr_d_reg),
        .fit_policy (req_reg.fit_policy),
        .block_size (req_reg.block_size),
        .found      (run_found),
        .best_start (run_best_start)
    );

    always_comb
    begin
        accept      = req_valid && (state_reg == cfa_pkg::ST_IDLE);
        alloc_bad   = (req_data.block_size == '0)
            || (req_data.owner_tag == cfa_pkg::FREE_MARK)
            || (req_data.fit_policy == cfa_pkg::FIT_ILLEGAL);
        free_bad    = (req_data.owner_tag == cfa_pkg::FREE_MARK);
        read_bad    = CMP_W'(req_data.cell_index) >= CMP_W'(NUM_CELLS);
        stream_done = (idx_reg == N_CNT) && !rd_vld_reg;
        fill_done   = CMP_W'(idx_reg) >= CMP_W'(req_reg.block_size);
        rsp_load    = (state_reg == cfa_pkg::ST_RESP) && (!rsp_valid_reg || rsp_ready);
        freed_sat   = (CMP_W'(cnt_reg) > CMP_W'(cfa_pkg::FREED_MAX))
            ? cfa_pkg::FREED_MAX : 7'(cnt_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfa_pkg::ST_CLEAR:
            begin
                if (idx_reg == N_LAST)
                begin
                    state_next = cfa_pkg::ST_IDLE;
                end
            end
            cfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_data.mode)
                        cfa_pkg::MODE_ALLOC:
                            state_next = alloc_bad ? cfa_pkg::ST_RESP : cfa_pkg::ST_SCAN;
                        cfa_pkg::MODE_FREE:
                            state_next = free_bad ? cfa_pkg::ST_RESP : cfa_pkg::ST_FREE;
                        cfa_pkg::MODE_COMPACT:
                            state_next = cfa_pkg::ST_COMPACT;
                        default:
                            state_next = read_bad ? cfa_pkg::ST_RESP : cfa_pkg::ST_READ;
                    endcase
                end
            end
            cfa_pkg::ST_SCAN:
            begin
                if (stream_done)
                begin
                    state_next = cfa_pkg::ST_DECIDE;
                end
            end
            cfa_pkg::ST_DECIDE:
            begin
                state_next = run_found ? cfa_pkg::ST_FILL : cfa_pkg::ST_RESP;
            end
            cfa_pkg::ST_FILL:
            begin
                if (fill_done)
                begin
                    state_next = cfa_pkg::ST_RESP;
                end
            end
            cfa_pkg::ST_FREE:
            begin
                if (stream_done)
                begin
                    state_next = cfa_pkg::ST_RESP;
                end
            end
            cfa_pkg::ST_COMPACT:
            begin
                if (stream_done)
                begin
                    state_next = cfa_pkg::ST_PAD;
                end
            end
            cfa_pkg::ST_PAD:
            begin
                if (wptr_reg == N_CNT)
                begin
                    state_next = cfa_pkg::ST_RESP;
                end
            end
            cfa_pkg::ST_READ:
            begin
                state_next = cfa_pkg::ST_READ_WAIT;
            end
            cfa_pkg::ST_READ_WAIT:
            begin
                state_next = cfa_pkg::ST_RESP;
            end
            cfa_pkg::ST_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = cfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next       = req_reg;
        res_next       = res_reg;
        idx_next       = idx_reg;
        wptr_next      = wptr_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        rd_addr_d_next = idx_reg[ADDR_W-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = idx_reg[ADDR_W-1:0];
        mem_wr_data    = cfa_pkg::FREE_MARK;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = idx_reg[ADDR_W-1:0];
        run_ctl        = '0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;

        unique case (state_reg)
            cfa_pkg::ST_CLEAR:
            begin
                mem_wr_en = 1'b1;
                idx_next  = idx_reg + 1'b1;
            end
            cfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next      = req_data;
                    res_next      = '0;
                    idx_next      = '0;
                    wptr_next     = '0;
                    cnt_next      = '0;
                    run_ctl.clear = 1'b1;
                    if (((req_data.mode == cfa_pkg::MODE_ALLOC) && alloc_bad)
                        || ((req_data.mode == cfa_pkg::MODE_FREE) && free_bad)
                        || ((req_data.mode == cfa_pkg::MODE_READ) && read_bad))
                    begin
                        res_next.status = cfa_pkg::STATUS_ILLEGAL;
                    end
                end
            end
            cfa_pkg::ST_SCAN, cfa_pkg::ST_FREE, cfa_pkg::ST_COMPACT:
            begin
                if (idx_reg != N_CNT)
                begin
                    mem_rd_en   = 1'b1;
                    rd_vld_next = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                end
                if (state_reg == cfa_pkg::ST_SCAN)
                begin
                    run_ctl.step    = rd_vld_reg || stream_done;
                    run_ctl.is_free = rd_vld_reg && (mem_rd_data == cfa_pkg::FREE_MARK);
                end
                else if (state_reg == cfa_pkg::ST_FREE)
                begin
                    mem_wr_addr = rd_addr_d_reg;
                    if (rd_vld_reg && (mem_rd_data == req_reg.owner_tag))
                    begin
                        mem_wr_en = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    mem_wr_addr = wptr_reg[ADDR_W-1:0];
                    mem_wr_data = mem_rd_data;
                    if (rd_vld_reg && (mem_rd_data != cfa_pkg::FREE_MARK))
                    begin
                        mem_wr_en = 1'b1;
                        wptr_next = wptr_reg + 1'b1;
                    end
                end
            end
            cfa_pkg::ST_DECIDE:
            begin
                idx_next = '0;
                if (run_found)
                begin
                    res_next.start_address = 6'(run_best_start);
                end
                else
                begin
                    res_next.status = cfa_pkg::STATUS_NO_FIT;
                end
            end
            cfa_pkg::ST_FILL:
            begin
                mem_wr_addr = run_best_start + idx_reg[ADDR_W-1:0];
                mem_wr_data = req_reg.owner_tag;
                if (!fill_done)
                begin
                    mem_wr_en = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            cfa_pkg::ST_PAD:
            begin
                mem_wr_addr = wptr_reg[ADDR_W-1:0];
                if (wptr_reg != N_CNT)
                begin
                    mem_wr_en = 1'b1;
                    wptr_next = wptr_reg + 1'b1;
                end
            end
            cfa_pkg::ST_READ:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ADDR_W'(req_reg.cell_index);
            end
            cfa_pkg::ST_READ_WAIT:
            begin
                res_next.cell_tag = mem_rd_data;
            end
            cfa_pkg::ST_RESP:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next             = res_reg;
                    rsp_data_next.cells_freed = freed_sat;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfa_pkg::ST_CLEAR;
            idx_reg       <= '0;
            wptr_reg      <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            wptr_reg      <= wptr_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        rd_addr_d_reg <= rd_addr_d_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign req_ready = (state_reg == cfa_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

### rtl/cfa_store.sv
`default_nettype none

module cfa_store #(
    parameter int NUM_CELLS = cfa_pkg::NUM_CELLS_DEFAULT,
    parameter int ADDR_W    = $clog2(NUM_CELLS)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [NUM_CELLS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/cfa_run_unit.sv
`default_nettype none

module cfa_run_unit #(
    parameter int NUM_CELLS = cfa_pkg::NUM_CELLS_DEFAULT,
    parameter int ADDR_W    = $clog2(NUM_CELLS),
    parameter int CNT_W     = $clog2(NUM_CELLS + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfa_pkg::run_ctl_t ctl,
    input  wire logic [ADDR_W-1:0] index,
    input  wire logic [1:0]        fit_policy,
    input  wire logic [6:0]        block_size,
    output logic                   found,
    output logic [ADDR_W-1:0]      best_start
);

    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    logic [ADDR_W-1:0] run_start_reg, run_start_next;
    logic [CNT_W-1:0]  run_len_reg, run_len_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;
    logic [CNT_W-1:0]  best_len_reg, best_len_next;
    logic              found_reg, found_next;
    logic              fits;
    logic              take;

    always_comb
    begin
        fits = (CMP_W'(run_len_reg) >= CMP_W'(block_size)) && (run_len_reg != '0);
        take = !found_reg
            || ((fit_policy == cfa_pkg::FIT_BEST) && (run_len_reg < best_len_reg))
            || ((fit_policy == cfa_pkg::FIT_WORST) && (run_len_reg > best_len_reg));
    end

    always_comb
    begin
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        found_next      = found_reg;
        if (ctl.clear)
        begin
            run_len_next    = '0;
            best_start_next = '0;
            best_len_next   = '0;
            found_next      = 1'b0;
        end
        else if (ctl.step)
        begin
            if (ctl.is_free)
            begin
                if (run_len_reg == '0)
                begin
                    run_start_next = index;
                end
                run_len_next = run_len_reg + 1'b1;
            end
            else
            begin
                if (fits && take)
                begin
                    found_next      = 1'b1;
                    best_start_next = run_start_reg;
                    best_len_next   = run_len_reg;
                end
                run_len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            run_start_reg  <= run_start_next;
            run_len_reg    <= run_len_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            found_reg      <= found_next;
        end
    end

    assign found      = found_reg;
    assign best_start = best_start_reg;

endmodule

`default_nettype wire

### rtl/cfa_checker.sv
`default_nettype none

module cfa_assertions (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire cfa_pkg::req_t req_data,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire cfa_pkg::rsp_t rsp_data
);

    // A request is worked on alone, so the block is busy right after taking one.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another request was still in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
        else $error("stalled result changed or was dropped");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_data.status == cfa_pkg::STATUS_OK)
            || (rsp_data.status == cfa_pkg::STATUS_NO_FIT)
            || (rsp_data.status == cfa_pkg::STATUS_ILLEGAL)))
        else $error("result carries an undefined status");

    // A refused request must not report an address, a count or a cell.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status != cfa_pkg::STATUS_OK))
            |-> ((rsp_data.start_address == '0) && (rsp_data.cells_freed == '0)
            && (rsp_data.cell_tag == '0)))
        else $error("failed request returned nonzero data");

endmodule

bind contiguous_fit_allocator cfa_assertions u_cfa_assertions (.*);

`default_nettype wire

### verif/cfa_checker.sv
`timescale 1ns / 1ps

module cfa_checker #(
    parameter int NUM_CELLS = cfa_pkg::NUM_CELLS_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_ready,
    input  wire cfa_pkg::req_t req_data,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_ready,
    input  wire cfa_pkg::rsp_t rsp_data,
    output int                 fail_count,
    output int                 rsp_pending
);

    logic [7:0]    cell_mem [NUM_CELLS];
    cfa_pkg::rsp_t rsp_due [$];

    function automatic logic find_hole(input logic [1:0] policy, input int size,
                                       output int start);
        logic found;
        logic take;
        logic is_free;
        int   best_start;
        int   best_len;
        int   run_start;
        int   run_len;
        found      = 1'b0;
        best_start = 0;
        best_len   = 0;
        run_start  = 0;
        run_len    = 0;
        for (int i = 0; i <= NUM_CELLS; i++)
        begin
            is_free = 1'b0;
            if (i < NUM_CELLS)
                is_free = (cell_mem[i] == cfa_pkg::FREE_MARK);
            if (is_free)
            begin
                if (run_len == 0)
                    run_start = i;
                run_len++;
            end
            else
            begin
                if (run_len >= size && run_len > 0)
                begin
                    if (!found)
                        take = 1'b1;
                    else if (policy == cfa_pkg::FIT_BEST)
                        take = (run_len < best_len);
                    else if (policy == cfa_pkg::FIT_WORST)
                        take = (run_len > best_len);
                    else
                        take = 1'b0;
                    if (take)
                    begin
                        found      = 1'b1;
                        best_start = run_start;
                        best_len   = run_len;
                    end
                end
                run_len = 0;
            end
        end
        start = best_start;
        return found;
    endfunction

    function automatic cfa_pkg::rsp_t serve_request(input cfa_pkg::req_t r);
        cfa_pkg::rsp_t e;
        logic hit;
        int   start;
        int   count;
        int   w;
        e     = '0;
        start = 0;
        count = 0;
        w     = 0;
        case (r.mode)
            cfa_pkg::MODE_ALLOC:
            begin
                if (r.block_size == 0 || r.owner_tag == cfa_pkg::FREE_MARK
                    || r.fit_policy == cfa_pkg::FIT_ILLEGAL)
                begin
                    e.status = cfa_pkg::STATUS_ILLEGAL;
                end
                else
                begin
                    hit = 1'b0;
                    if (int'(r.block_size) <= NUM_CELLS)
                        hit = find_hole(r.fit_policy, int'(r.block_size), start);
                    if (!hit)
                    begin
                        e.status = cfa_pkg::STATUS_NO_FIT;
                    end
                    else
                    begin
                        for (int k = 0; k < int'(r.block_size); k++)
                            if (start + k < NUM_CELLS)
                                cell_mem[start + k] = r.owner_tag;
                        e.status        = cfa_pkg::STATUS_OK;
                        e.start_address = start[5:0];
                    end
                end
            end
            cfa_pkg::MODE_FREE:
            begin
                if (r.owner_tag == cfa_pkg::FREE_MARK)
                begin
                    e.status = cfa_pkg::STATUS_ILLEGAL;
                end
                else
                begin
                    for (int i = 0; i < NUM_CELLS; i++)
                        if (cell_mem[i] == r.owner_tag)
                        begin
                            cell_mem[i] = cfa_pkg::FREE_MARK;
                            count++;
                        end
                    e.status      = cfa_pkg::STATUS_OK;
                    e.cells_freed = (count > 127) ? cfa_pkg::FREED_MAX : count[6:0];
                end
            end
            cfa_pkg::MODE_COMPACT:
            begin
                for (int i = 0; i < NUM_CELLS; i++)
                    if (cell_mem[i] != cfa_pkg::FREE_MARK)
                    begin
                        cell_mem[w] = cell_mem[i];
                        w++;
                    end
                for (int i = w; i < NUM_CELLS; i++)
                    cell_mem[i] = cfa_pkg::FREE_MARK;
                e.status = cfa_pkg::STATUS_OK;
            end
            default:
            begin
                if (int'(r.cell_index) < NUM_CELLS)
                begin
                    e.status   = cfa_pkg::STATUS_OK;
                    e.cell_tag = cell_mem[r.cell_index];
                end
                else
                begin
                    e.status = cfa_pkg::STATUS_ILLEGAL;
                end
            end
        endcase
        return e;
    endfunction

    task automatic flag_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cfa_pkg::rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CELLS; i++)
                cell_mem[i] = cfa_pkg::FREE_MARK;
            rsp_due.delete();
            fail_count  = 0;
            rsp_pending <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $display("%0t: response with none expected, expected nothing, actual %h",
                             $time, rsp_data);
                    fail_count++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    flag_field("status", int'(want.status), int'(rsp_data.status));
                    flag_field("start_address", int'(want.start_address),
                               int'(rsp_data.start_address));
                    flag_field("cells_freed", int'(want.cells_freed),
                               int'(rsp_data.cells_freed));
                    flag_field("cell_tag", int'(want.cell_tag), int'(rsp_data.cell_tag));
                end
            end
            if (req_valid && req_ready)
                rsp_due.push_back(serve_request(req_data));
            rsp_pending <= rsp_due.size();
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    logic          clk;
    logic          rst_n;
    logic          req_valid = 1'b0;
    logic          req_ready;
    cfa_pkg::req_t req_data  = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    cfa_pkg::rsp_t rsp_data;
    int            fail_count;
    int            rsp_pending;
    int            tx_idle_pct = 6;
    int            rx_idle_pct = 67;

    contiguous_fit_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    cfa_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp_data),
        .fail_count  (fail_count),
        .rsp_pending (rsp_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    function automatic cfa_pkg::req_t make_req(input logic [1:0] mode, input logic [1:0] fit,
                                               input logic [7:0] tag, input logic [6:0] size,
                                               input logic [5:0] idx);
        cfa_pkg::req_t r;
        r.mode       = mode;
        r.fit_policy = fit;
        r.owner_tag  = tag;
        r.block_size = size;
        r.cell_index = idx;
        return r;
    endfunction

    task automatic send_request(input cfa_pkg::req_t r);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    initial
    begin
        #16ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        cfa_pkg::req_t r;
        int            pick;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_req(cfa_pkg::MODE_READ, cfa_pkg::FIT_FIRST, 8'd0, 7'd0, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_FIRST, 8'd1, 7'd0, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_FIRST, cfa_pkg::FREE_MARK,
                              7'd4, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_ILLEGAL, 8'd1, 7'd4, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_FIRST, 8'd1, 7'd65, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_WORST, 8'd1, 7'd127, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_FIRST, 8'd255, 7'd64, 6'd0));
        send_request(make_req(cfa_pkg::MODE_READ, cfa_pkg::FIT_FIRST, 8'd0, 7'd0, 6'd63));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_BEST, 8'd9, 7'd1, 6'd0));
        send_request(make_req(cfa_pkg::MODE_FREE, cfa_pkg::FIT_FIRST, 8'd255, 7'd0, 6'd0));
        send_request(make_req(cfa_pkg::MODE_FREE, cfa_pkg::FIT_FIRST, cfa_pkg::FREE_MARK,
                              7'd0, 6'd0));
        send_request(make_req(cfa_pkg::MODE_FREE, cfa_pkg::FIT_FIRST, 8'd7, 7'd0, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_FIRST, 8'd0, 7'd4, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_FIRST, 8'd1, 7'd8, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_FIRST, 8'd2, 7'd2, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_FIRST, 8'd3, 7'd8, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_FIRST, 8'd4, 7'd2, 6'd0));
        send_request(make_req(cfa_pkg::MODE_FREE, cfa_pkg::FIT_FIRST, 8'd1, 7'd0, 6'd0));
        send_request(make_req(cfa_pkg::MODE_FREE, cfa_pkg::FIT_FIRST, 8'd3, 7'd0, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_BEST, 8'd5, 7'd3, 6'd0));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_WORST, 8'd6, 7'd2, 6'd0));
        send_request(make_req(cfa_pkg::MODE_FREE, cfa_pkg::FIT_FIRST, 8'd2, 7'd0, 6'd0));
        send_request(make_req(cfa_pkg::MODE_COMPACT, cfa_pkg::FIT_FIRST, 8'd0, 7'd0, 6'd0));
        send_request(make_req(cfa_pkg::MODE_READ, cfa_pkg::FIT_FIRST, 8'd0, 7'd0, 6'd1));
        send_request(make_req(cfa_pkg::MODE_ALLOC, cfa_pkg::FIT_BEST, 8'd8, 7'd64, 6'd42));

        for (int n = 0; n < 750; n++)
        begin
            if (n == 250)
            begin
                tx_idle_pct = 67;
                rx_idle_pct = 6;
            end
            else if (n == 500)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            r = make_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 2)),
                         8'($urandom_range(0, 255)), 7'($urandom_range(1, 10)),
                         6'($urandom_range(0, 63)));
            pick = $urandom_range(0, 99);
            if (pick < 45)
                r.mode = cfa_pkg::MODE_ALLOC;
            else if (pick < 70)
                r.mode = cfa_pkg::MODE_FREE;
            else if (pick < 75)
                r.mode = cfa_pkg::MODE_COMPACT;
            else
                r.mode = cfa_pkg::MODE_READ;
            pick = $urandom_range(0, 99);
            if (pick < 75)
                r.owner_tag = {3'($urandom_range(0, 7)), 5'h15};
            else if (pick < 80)
                r.owner_tag = cfa_pkg::FREE_MARK;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                r.block_size = 7'd0;
            else if (pick < 10)
                r.block_size = 7'($urandom_range(11, 40));
            else if (pick < 15)
                r.block_size = 7'($urandom_range(41, 127));
            if ($urandom_range(0, 99) < 5)
                r.fit_policy = cfa_pkg::FIT_ILLEGAL;
            send_request(r);
        end
        req_valid <= 1'b0;
        @(posedge clk);
        while (rsp_pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
